[rtl/lstu_pkg.sv]
// Shared types and constants of the load/store transfer unit.
`default_nettype none

package lstu_pkg;

    typedef enum logic [1:0] {
        KIND_MEM_READ  = 2'd0,
        KIND_MEM_WRITE = 2'd1,
        KIND_REG_WRITE = 2'd2
    } kind_t;

    localparam logic MODE_INSTR     = 1'b0;
    localparam logic MODE_READ_DATA = 1'b1;

    localparam logic [31:0] WORD_ALIGN_MASK = 32'hFFFF_FFFC;
    localparam logic [31:0] BYTE_MASK       = 32'h0000_00FF;
    localparam logic [3:0]  PC_REG          = 4'd15;
    localparam logic [31:0] PC_STORE_ADJUST = 32'd4;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] address;
        logic [31:0] write_data;
        logic        size_byte;
        logic [3:0]  reg_number;
        logic [31:0] reg_value;
        logic        has_wb;
        logic [3:0]  wb_number;
        logic [31:0] wb_value;
    } entry_t;

endpackage

`default_nettype wire

[rtl/lstu_front.sv]
// Front end: accepts input beats, computes addresses and load data, tracks the pending load.
`default_nettype none

module lstu_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic           mode,
    input  wire logic           pre_index,
    input  wire logic           add_offset,
    input  wire logic           byte_access,
    input  wire logic           write_back,
    input  wire logic           is_load,
    input  wire logic [3:0]     base_index,
    input  wire logic [3:0]     data_index,
    input  wire logic [31:0]    base_value,
    input  wire logic [31:0]    offset_value,
    input  wire logic [31:0]    store_value,
    input  wire logic [31:0]    read_data,
    output logic                push,
    output lstu_pkg::entry_t    entry
);

    logic        load_pending_reg;
    logic        load_pending_next;
    logic [1:0]  pending_low_bits_reg;
    logic [1:0]  pending_low_bits_next;
    logic        pending_is_byte_reg;
    logic        pending_is_byte_next;
    logic [3:0]  pending_dest_reg;
    logic [3:0]  pending_dest_next;

    logic [31:0] updated;
    logic [31:0] eff;
    logic [31:0] req_addr;
    logic        do_wb;
    logic [31:0] store_data;
    logic [31:0] rotated;
    logic [31:0] load_value;

    always_comb
    begin
        updated    = add_offset ? (base_value + offset_value) : (base_value - offset_value);
        eff        = pre_index ? updated : base_value;
        req_addr   = byte_access ? eff : (eff & lstu_pkg::WORD_ALIGN_MASK);
        do_wb      = !pre_index || write_back;
        store_data = store_value
                     + ((data_index == lstu_pkg::PC_REG) ? lstu_pkg::PC_STORE_ADJUST : 32'd0);
        if (byte_access)
        begin
            store_data = store_data & lstu_pkg::BYTE_MASK;
        end
    end

    always_comb
    begin
        case (pending_low_bits_reg)
            2'd0:    rotated = read_data;
            2'd1:    rotated = {read_data[7:0], read_data[31:8]};
            2'd2:    rotated = {read_data[15:0], read_data[31:16]};
            2'd3:    rotated = {read_data[23:0], read_data[31:24]};
            default: rotated = read_data;
        endcase
        load_value = pending_is_byte_reg ? (read_data & lstu_pkg::BYTE_MASK) : rotated;
    end

    always_comb
    begin
        entry = '0;
        push  = 1'b0;
        if (mode == lstu_pkg::MODE_READ_DATA)
        begin
            push             = accept && load_pending_reg;
            entry.kind       = lstu_pkg::KIND_REG_WRITE;
            entry.reg_number = pending_dest_reg;
            entry.reg_value  = load_value;
        end
        else
        begin
            push            = accept;
            entry.kind      = is_load ? lstu_pkg::KIND_MEM_READ : lstu_pkg::KIND_MEM_WRITE;
            entry.address   = req_addr;
            entry.write_data = is_load ? 32'd0 : store_data;
            entry.size_byte = byte_access;
            entry.has_wb    = do_wb;
            entry.wb_number = base_index;
            entry.wb_value  = updated;
        end
    end

    always_comb
    begin
        load_pending_next     = load_pending_reg;
        pending_low_bits_next = pending_low_bits_reg;
        pending_is_byte_next  = pending_is_byte_reg;
        pending_dest_next     = pending_dest_reg;
        if (accept)
        begin
            if (mode == lstu_pkg::MODE_READ_DATA)
            begin
                load_pending_next = 1'b0;
            end
            else if (is_load)
            begin
                load_pending_next     = 1'b1;
                pending_low_bits_next = eff[1:0];
                pending_is_byte_next  = byte_access;
                pending_dest_next     = data_index;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pending_reg     <= 1'b0;
            pending_low_bits_reg <= 2'd0;
            pending_is_byte_reg  <= 1'b0;
            pending_dest_reg     <= 4'd0;
        end
        else
        begin
            load_pending_reg     <= load_pending_next;
            pending_low_bits_reg <= pending_low_bits_next;
            pending_is_byte_reg  <= pending_is_byte_next;
            pending_dest_reg     <= pending_dest_next;
        end
    end

endmodule

`default_nettype wire

[rtl/lstu_queue.sv]
// Short queue of classified transfers between the front and back ends.
`default_nettype none

module lstu_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire lstu_pkg::entry_t push_entry,
    input  wire logic             pop,
    output lstu_pkg::entry_t      head,
    output logic                  empty,
    output logic                  full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    lstu_pkg::entry_t slots_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    always_comb
    begin
        empty   = (count_reg == '0);
        full    = (count_reg == FULL_COUNT);
        do_push = push && !full;
        do_pop  = pop && !empty;
        head    = slots_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/lstu_back.sv]
// Back end: expands queued transfers into result beats behind an output register.
`default_nettype none

module lstu_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lstu_pkg::entry_t head,
    input  wire logic             empty,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [1:0]            kind,
    output logic [31:0]           address,
    output logic [31:0]           write_data,
    output logic                  size_byte,
    output logic [3:0]            reg_number,
    output logic [31:0]           reg_value,
    output logic                  last
);

    logic            out_valid_reg;
    logic            out_valid_next;
    logic            second_reg;
    logic            second_next;
    lstu_pkg::kind_t kind_reg;
    lstu_pkg::kind_t kind_next;
    logic [31:0]     address_reg;
    logic [31:0]     address_next;
    logic [31:0]     write_data_reg;
    logic [31:0]     write_data_next;
    logic            size_byte_reg;
    logic            size_byte_next;
    logic [3:0]      reg_number_reg;
    logic [3:0]      reg_number_next;
    logic [31:0]     reg_value_reg;
    logic [31:0]     reg_value_next;
    logic            last_reg;
    logic            last_next;
    logic [3:0]      wb_number_reg;
    logic [3:0]      wb_number_next;
    logic [31:0]     wb_value_reg;
    logic [31:0]     wb_value_next;
    logic            load_out;

    always_comb
    begin
        load_out        = !out_valid_reg || !out_stall;
        pop             = load_out && !second_reg && !empty;
        out_valid_next  = out_valid_reg;
        second_next     = second_reg;
        kind_next       = kind_reg;
        address_next    = address_reg;
        write_data_next = write_data_reg;
        size_byte_next  = size_byte_reg;
        reg_number_next = reg_number_reg;
        reg_value_next  = reg_value_reg;
        last_next       = last_reg;
        wb_number_next  = wb_number_reg;
        wb_value_next   = wb_value_reg;
        if (load_out)
        begin
            if (second_reg)
            begin
                out_valid_next  = 1'b1;
                second_next     = 1'b0;
                kind_next       = lstu_pkg::KIND_REG_WRITE;
                address_next    = 32'd0;
                write_data_next = 32'd0;
                size_byte_next  = 1'b0;
                reg_number_next = wb_number_reg;
                reg_value_next  = wb_value_reg;
                last_next       = 1'b1;
            end
            else if (!empty)
            begin
                out_valid_next  = 1'b1;
                second_next     = head.has_wb;
                kind_next       = head.kind;
                address_next    = head.address;
                write_data_next = head.write_data;
                size_byte_next  = head.size_byte;
                reg_number_next = head.reg_number;
                reg_value_next  = head.reg_value;
                last_next       = !head.has_wb;
                wb_number_next  = head.wb_number;
                wb_value_next   = head.wb_value;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        address_reg    <= address_next;
        write_data_reg <= write_data_next;
        size_byte_reg  <= size_byte_next;
        reg_number_reg <= reg_number_next;
        reg_value_reg  <= reg_value_next;
        last_reg       <= last_next;
        wb_number_reg  <= wb_number_next;
        wb_value_reg   <= wb_value_next;
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign address    = address_reg;
    assign write_data = write_data_reg;
    assign size_byte  = size_byte_reg;
    assign reg_number = reg_number_reg;
    assign reg_value  = reg_value_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

[rtl/load_store_transfer_unit.sv]
// Top level of the load/store transfer unit: front end, transfer queue and back end.
// An input beat's first result is registered in the queue, then in the output register.
// Throughput: one input beat per cycle unless the queue is full; one result beat
// per cycle unless out_stall; a writeback item gives two beats, a burst the queue absorbs.
// Input stalls only while the QUEUE_DEPTH-entry transfer queue is full.
// Reset clears the pending load, the queue pointers and the output valid.
`default_nettype none

module load_store_transfer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic        pre_index,
    input  wire logic        add_offset,
    input  wire logic        byte_access,
    input  wire logic        write_back,
    input  wire logic        is_load,
    input  wire logic [3:0]  base_index,
    input  wire logic [3:0]  data_index,
    input  wire logic [31:0] base_value,
    input  wire logic [31:0] offset_value,
    input  wire logic [31:0] store_value,
    input  wire logic [31:0] read_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [31:0]      address,
    output logic [31:0]      write_data,
    output logic             size_byte,
    output logic [3:0]       reg_number,
    output logic [31:0]      reg_value,
    output logic             last
);

    logic             accept;
    logic             push;
    lstu_pkg::entry_t push_entry;
    lstu_pkg::entry_t head;
    logic             empty;
    logic             full;
    logic             pop;

    assign in_stall = full;
    assign accept   = in_valid && !in_stall;

    lstu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .mode         (mode),
        .pre_index    (pre_index),
        .add_offset   (add_offset),
        .byte_access  (byte_access),
        .write_back   (write_back),
        .is_load      (is_load),
        .base_index   (base_index),
        .data_index   (data_index),
        .base_value   (base_value),
        .offset_value (offset_value),
        .store_value  (store_value),
        .read_data    (read_data),
        .push         (push),
        .entry        (push_entry)
    );

    lstu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    lstu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .address    (address),
        .write_data (write_data),
        .size_byte  (size_byte),
        .reg_number (reg_number),
        .reg_value  (reg_value),
        .last       (last)
    );

endmodule

`default_nettype wire

[rtl/lstu_checker.sv]
// Port checker of the load/store transfer unit and its bind to the top level.
`default_nettype none

module lstu_port_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] address,
    input  wire logic [31:0] write_data,
    input  wire logic        size_byte,
    input  wire logic [3:0]  reg_number,
    input  wire logic [31:0] reg_value,
    input  wire logic        last
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(address)
            && $stable(write_data) && $stable(reg_value) && $stable(last))
        else $error("stalled result beat changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == lstu_pkg::KIND_MEM_READ) || (kind == lstu_pkg::KIND_MEM_WRITE)
            || (kind == lstu_pkg::KIND_REG_WRITE))
        else $error("result beat with unknown kind");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == lstu_pkg::KIND_REG_WRITE)
            |-> (address == 32'd0) && (write_data == 32'd0) && !size_byte && last)
        else $error("register write beat malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != lstu_pkg::KIND_REG_WRITE)
            |-> (reg_number == 4'd0) && (reg_value == 32'd0)
            && ((kind != lstu_pkg::KIND_MEM_READ) || (write_data == 32'd0)))
        else $error("memory request beat malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last
            |=> out_valid && (kind == lstu_pkg::KIND_REG_WRITE) && last)
        else $error("writeback beat did not follow its request");

endmodule

bind load_store_transfer_unit lstu_port_checker u_lstu_port_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .address    (address),
    .write_data (write_data),
    .size_byte  (size_byte),
    .reg_number (reg_number),
    .reg_value  (reg_value),
    .last       (last)
);

`default_nettype wire

[bench/lstu_checker.sv]
// Checker for the load/store transfer unit: predicts every result beat and compares it.
`default_nettype none

module lstu_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        mode,
    input  wire logic        pre_index,
    input  wire logic        add_offset,
    input  wire logic        byte_access,
    input  wire logic        write_back,
    input  wire logic        is_load,
    input  wire logic [3:0]  base_index,
    input  wire logic [3:0]  data_index,
    input  wire logic [31:0] base_value,
    input  wire logic [31:0] offset_value,
    input  wire logic [31:0] store_value,
    input  wire logic [31:0] read_data,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] address,
    input  wire logic [31:0] write_data,
    input  wire logic        size_byte,
    input  wire logic [3:0]  reg_number,
    input  wire logic [31:0] reg_value,
    input  wire logic        last,
    output int               mismatches,
    output int               outstanding
);

    typedef struct packed {
        lstu_pkg::kind_t kind;
        logic [31:0]     address;
        logic [31:0]     write_data;
        logic            size_byte;
        logic [3:0]      reg_number;
        logic [31:0]     reg_value;
        logic            last;
    } transfer_result_t;

    transfer_result_t due_results[$];

    logic       load_waiting;
    logic [1:0] load_low_bits;
    logic       load_is_byte;
    logic [3:0] load_dest;

    task automatic report(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s is %h, want %h", name, got, want));
    endtask

    task automatic predict_transfer();
        logic [31:0]      updated;
        logic [31:0]      eff;
        logic [31:0]      wdata;
        logic             do_wb;
        transfer_result_t r;
        r = '0;
        if (mode == lstu_pkg::MODE_READ_DATA)
        begin
            if (load_waiting)
            begin
                r.kind = lstu_pkg::KIND_REG_WRITE;
                r.reg_number = load_dest;
                if (load_is_byte)
                    r.reg_value = read_data & lstu_pkg::BYTE_MASK;
                else
                    r.reg_value = 32'({read_data, read_data} >> {load_low_bits, 3'b000});
                r.last = 1'b1;
                due_results.push_back(r);
                load_waiting = 1'b0;
            end
        end
        else
        begin
            updated = add_offset ? base_value + offset_value : base_value - offset_value;
            eff = pre_index ? updated : base_value;
            do_wb = !pre_index || write_back;
            r.address = byte_access ? eff : (eff & lstu_pkg::WORD_ALIGN_MASK);
            r.size_byte = byte_access;
            r.last = !do_wb;
            if (is_load)
            begin
                r.kind = lstu_pkg::KIND_MEM_READ;
                load_waiting = 1'b1;
                load_low_bits = eff[1:0];
                load_is_byte = byte_access;
                load_dest = data_index;
            end
            else
            begin
                r.kind = lstu_pkg::KIND_MEM_WRITE;
                wdata = store_value;
                if (data_index == lstu_pkg::PC_REG)
                    wdata = wdata + lstu_pkg::PC_STORE_ADJUST;
                if (byte_access)
                    wdata = wdata & lstu_pkg::BYTE_MASK;
                r.write_data = wdata;
            end
            due_results.push_back(r);
            if (do_wb)
            begin
                r = '0;
                r.kind = lstu_pkg::KIND_REG_WRITE;
                r.reg_number = base_index;
                r.reg_value = updated;
                r.last = 1'b1;
                due_results.push_back(r);
            end
        end
    endtask

    task automatic check_result();
        transfer_result_t w;
        if (due_results.size() == 0)
            report($sformatf("result beat of kind %0d with none due", kind));
        else
        begin
            w = due_results.pop_front();
            check_field("kind", 32'(kind), 32'(w.kind));
            check_field("address", address, w.address);
            check_field("write_data", write_data, w.write_data);
            check_field("size_byte", 32'(size_byte), 32'(w.size_byte));
            check_field("reg_number", 32'(reg_number), 32'(w.reg_number));
            check_field("reg_value", reg_value, w.reg_value);
            check_field("last", 32'(last), 32'(w.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_results.delete();
            load_waiting = 1'b0;
            load_low_bits = 2'b00;
            load_is_byte = 1'b0;
            load_dest = 4'd0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                predict_transfer();
            outstanding = due_results.size();
        end
    end

endmodule

`default_nettype wire

[bench/tb_load_store_transfer_unit.sv]
// Testbench top for the load/store transfer unit: clock, reset, stimulus, receiver, verdict.
`default_nettype none

module tb_load_store_transfer_unit;

    typedef struct packed {
        logic        mode;
        logic        pre_index;
        logic        add_offset;
        logic        byte_access;
        logic        write_back;
        logic        is_load;
        logic [3:0]  base_index;
        logic [3:0]  data_index;
        logic [31:0] base_value;
        logic [31:0] offset_value;
        logic [31:0] store_value;
        logic [31:0] read_data;
    } transfer_beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic        pre_index;
    logic        add_offset;
    logic        byte_access;
    logic        write_back;
    logic        is_load;
    logic [3:0]  base_index;
    logic [3:0]  data_index;
    logic [31:0] base_value;
    logic [31:0] offset_value;
    logic [31:0] store_value;
    logic [31:0] read_data;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [31:0] address;
    logic [31:0] write_data;
    logic        size_byte;
    logic [3:0]  reg_number;
    logic [31:0] reg_value;
    logic        last;
    int          mismatches;
    int          outstanding;

    int          items_done;
    logic        load_open;
    logic        calm;

    load_store_transfer_unit uut (.*);

    lstu_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: return 32'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    function automatic transfer_beat_t random_instr(input logic ld);
        transfer_beat_t b;
        b.mode = lstu_pkg::MODE_INSTR;
        b.pre_index = 1'($urandom_range(1));
        b.add_offset = 1'($urandom_range(1));
        b.byte_access = 1'($urandom_range(1));
        b.write_back = 1'($urandom_range(1));
        b.is_load = ld;
        b.base_index = 4'($urandom_range(15));
        b.data_index = 4'($urandom_range(15));
        b.base_value = rand_word();
        b.offset_value = rand_word();
        b.store_value = rand_word();
        b.read_data = $urandom;
        return b;
    endfunction

    function automatic transfer_beat_t data_beat(input logic [31:0] rdata);
        transfer_beat_t b;
        b = random_instr(1'($urandom_range(1)));
        b.mode = lstu_pkg::MODE_READ_DATA;
        b.read_data = rdata;
        return b;
    endfunction

    function automatic transfer_beat_t instr(input logic pre, input logic add,
                                             input logic byt, input logic wb,
                                             input logic ld, input logic [3:0] rn,
                                             input logic [3:0] rd,
                                             input logic [31:0] base,
                                             input logic [31:0] off,
                                             input logic [31:0] sval);
        transfer_beat_t b;
        b = random_instr(ld);
        b.pre_index = pre;
        b.add_offset = add;
        b.byte_access = byt;
        b.write_back = wb;
        b.base_index = rn;
        b.data_index = rd;
        b.base_value = base;
        b.offset_value = off;
        b.store_value = sval;
        return b;
    endfunction

    task automatic offer(input transfer_beat_t b);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= b.mode;
        pre_index <= b.pre_index;
        add_offset <= b.add_offset;
        byte_access <= b.byte_access;
        write_back <= b.write_back;
        is_load <= b.is_load;
        base_index <= b.base_index;
        data_index <= b.data_index;
        base_value <= b.base_value;
        offset_value <= b.offset_value;
        store_value <= b.store_value;
        read_data <= b.read_data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (b.mode == lstu_pkg::MODE_INSTR)
        begin
            if (b.is_load)
                load_open = 1'b1;
            items_done++;
        end
        else if (load_open)
        begin
            load_open = 1'b0;
            items_done++;
        end
    endtask

    initial
    begin
        int cyc;
        int hold_left;
        cyc = 0;
        hold_left = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc == 400 || cyc == 2000)
                hold_left = 60;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 24);
        end
    end

    initial
    begin
        int pick;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = lstu_pkg::MODE_INSTR;
        pre_index = 1'b0;
        add_offset = 1'b0;
        byte_access = 1'b0;
        write_back = 1'b0;
        is_load = 1'b0;
        base_index = 4'd0;
        data_index = 4'd0;
        base_value = 32'h0;
        offset_value = 32'h0;
        store_value = 32'h0;
        read_data = 32'h0;
        items_done = 0;
        load_open = 1'b0;
        calm = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drop a return with no load waiting
        offer(data_beat(32'hDEAD_BEEF));
        offer(instr(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd1, 4'd2, 32'h0000_1000, 32'h4,
                    32'h1234_5678));
        offer(instr(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0, 4'd3, 32'h0, 32'h1, 32'hA5A5_A5A5));
        offer(instr(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 4'd15, 4'd15, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFC));
        offer(instr(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 4'd7, 4'd15, 32'h100, 32'h3,
                    32'h0000_00FE));
        for (int k = 0; k < 4; k++)
        begin
            offer(instr(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 4'd5, 4'd6, 32'h2000, 32'(k), 32'h0));
            offer(data_beat(32'h1122_3344));
        end
        // writeback and load hit the same register
        offer(instr(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 4'd9, 4'd9, 32'h3003, 32'h10, 32'h0));
        offer(data_beat(32'hFFFF_FFFF));
        offer(instr(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 4'd2, 4'd3, 32'h10, 32'h1, 32'h0));
        offer(instr(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd4, 4'd8, 32'h10, 32'h2, 32'h0));
        offer(instr(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0, 4'd1, 32'h40, 32'h0, 32'hFFFF_FFFF));
        offer(data_beat(32'h8765_4321));
        offer(data_beat(32'h0000_0000));

        while (items_done < 1630)
        begin
            calm = (items_done >= 700 && items_done < 1000);
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                offer(random_instr(1'b1));
                repeat ($urandom_range(2))
                    offer(random_instr(1'b0));
                offer(data_beat(rand_word()));
            end
            else if (pick < 90)
                offer(random_instr(1'b0));
            else if (pick < 95)
                offer(random_instr(1'b1));
            else
                offer(data_beat($urandom));
        end
        calm = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
